// ===== rtl/mse_pkg.sv =====
// Shared types and encodings for the MIPS subset execute unit.
package mse_pkg;

	localparam int unsigned XLEN = 32;
	localparam int unsigned RegCount = 32;
	localparam int unsigned RegIdxW = 5;
	localparam int unsigned LenW = 11;

	// Instruction memory depth in words; the program length is clamped to it.
	localparam logic [XLEN-1:0] PROG_DEPTH = 32'd1024;

	// Primary opcodes.
	localparam logic [5:0] OP_SPECIAL = 6'h00;
	localparam logic [5:0] OP_BEQ     = 6'h04;
	localparam logic [5:0] OP_BNE     = 6'h05;
	localparam logic [5:0] OP_ADDI    = 6'h08;

	// Function codes under the special opcode.
	localparam logic [5:0] FN_SLL = 6'h00;
	localparam logic [5:0] FN_SRL = 6'h02;
	localparam logic [5:0] FN_SRA = 6'h03;
	localparam logic [5:0] FN_ADD = 6'h20;
	localparam logic [5:0] FN_AND = 6'h24;
	localparam logic [5:0] FN_OR  = 6'h25;
	localparam logic [5:0] FN_SLT = 6'h2A;

	// One result item; fields listed from the highest bit down.
	typedef struct packed {
		logic [XLEN-1:0]    dest_value;
		logic [RegIdxW-1:0] dest_index;
		logic               reg_written;
		logic [XLEN-1:0]    next_pc;
		logic               unknown_op;
		logic               done_res;
	} res_t;

endpackage

// ===== rtl/mse_ram.sv =====
// Generic RAM with one write port and two registered read ports.
module mse_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_a,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_a <= mem_q[raddr_a];
			rdata_b <= mem_q[raddr_b];
		end
	end

endmodule

// ===== rtl/mse_exec.sv =====
// Decode and execute of one instruction word against its source operands.
module mse_exec (
	input  logic [mse_pkg::XLEN-1:0] instr,
	input  logic [mse_pkg::XLEN-1:0] opa,
	input  logic [mse_pkg::XLEN-1:0] opb,
	input  logic [mse_pkg::XLEN-1:0] pc,
	input  logic [mse_pkg::LenW-1:0] prog_len,
	output mse_pkg::res_t            res
);
	import mse_pkg::*;

	logic [5:0]         op;
	logic [5:0]         fn;
	logic [RegIdxW-1:0] rt;
	logic [RegIdxW-1:0] rd;
	logic [4:0]         sa;
	logic [XLEN-1:0]    imm_sx;
	logic [XLEN-1:0]    pc4;
	logic [XLEN-1:0]    br_tgt;
	logic [XLEN-1:0]    limit;
	logic               done;
	logic               wr;
	logic               unk;
	logic               take;
	logic [RegIdxW-1:0] dst;
	logic [XLEN-1:0]    val;

	assign op     = instr[31:26];
	assign rt     = instr[20:16];
	assign rd     = instr[15:11];
	assign sa     = instr[10:6];
	assign fn     = instr[5:0];
	assign imm_sx = {{16{instr[15]}}, instr[15:0]};
	assign pc4    = pc + 32'd4;
	assign br_tgt = pc4 + {imm_sx[XLEN-3:0], 2'b00};

	// Effective length is the configured length clamped to the memory depth.
	assign limit = ({21'd0, prog_len} > PROG_DEPTH) ? PROG_DEPTH : {21'd0, prog_len};
	assign done  = {2'b00, pc[XLEN-1:2]} >= limit;

	always_comb begin
		wr   = 1'b0;
		unk  = 1'b0;
		take = 1'b0;
		dst  = rd;
		val  = '0;
		unique case (op)
			OP_SPECIAL: begin
				wr = 1'b1;
				unique case (fn)
					FN_ADD: val = opa + opb;
					FN_AND: val = opa & opb;
					FN_OR:  val = opa | opb;
					FN_SLL: val = opb << sa;
					FN_SLT: val = {31'd0, $signed(opa) < $signed(opb)};
					FN_SRA: val = $unsigned($signed(opb) >>> sa);
					FN_SRL: val = opb >> sa;
					default: begin
						wr  = 1'b0;
						unk = 1'b1;
					end
				endcase
			end
			OP_ADDI: begin
				wr  = 1'b1;
				dst = rt;
				val = opa + imm_sx;
			end
			OP_BEQ: take = (opa == opb);
			OP_BNE: take = (opa != opb);
			default: unk = 1'b1;
		endcase

		res = '0;
		if (done) begin
			res.done_res = 1'b1;
			res.next_pc  = pc;
		end else begin
			res.unknown_op = unk;
			res.next_pc    = take ? br_tgt : pc4;
			// Register zero is hardwired; a write to it is dropped.
			if (wr && (dst != '0)) begin
				res.reg_written = 1'b1;
				res.dest_index  = dst;
				res.dest_value  = val;
			end
		end
	end

endmodule

// ===== rtl/mips_subset_execute_unit.sv =====
// Top level of the MIPS subset execute unit: input stage, register file, result register.
//
//  Channel  Direction  Handshake           Payload
//  s_*      in         s_tvalid/s_tready   s_tdata = instr_word (32 bits)
//  m_*      out        m_tvalid/m_tready   m_tdata = one result item (72 bits)
//  cfg_*    in         cfg_wen             cfg_wdata = program_length (11 bits)
//
// Each item passes through the input stage and the result register; a new item
// is accepted in every cycle while the output does not stall. Acceptance reads
// both source registers from the register file RAM; the input stage then executes,
// writes the destination register and the PC, and loads the result register.
// Reset clears the program counter, the program length and the register valid
// bits, so every register reads as zero until it is first written.
// A stall on the output holds the result register and then the input stage.
module mips_subset_execute_unit (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     s_tvalid,
	output logic                     s_tready,
	// instr_word [31:0]
	input  logic [31:0]              s_tdata,
	output logic                     m_tvalid,
	input  logic                     m_tready,
	// done_res [0], unknown_op [1], next_pc [33:2], reg_written [34],
	// dest_index [39:35], dest_value [71:40]
	output logic [71:0]              m_tdata,
	input  logic                     cfg_wen,
	input  logic [mse_pkg::LenW-1:0] cfg_wdata
);
	import mse_pkg::*;

	// Input stage. The operands come from the RAM's registered read ports,
	// qualified by the valid bit of each entry and overridden by a bypass when
	// the item ahead wrote the same register at the edge this item was taken.
	logic               vld_s1;
	logic [XLEN-1:0]    instr_s1;
	logic               rdv_a_s1;
	logic               rdv_b_s1;
	logic               fwd_a_s1;
	logic               fwd_b_s1;
	logic [XLEN-1:0]    fwd_val_s1;

	// Architectural state and the result register.
	logic [XLEN-1:0]     pc_q;
	logic [LenW-1:0]     len_q;
	logic [RegCount-1:0] rf_vld_q;
	logic                out_vld_q;
	res_t                out_q;

	logic               adv;
	logic               acc;
	logic               wr_en;
	logic [RegIdxW-1:0] rs_in;
	logic [RegIdxW-1:0] rt_in;
	logic [XLEN-1:0]    ram_a;
	logic [XLEN-1:0]    ram_b;
	logic [XLEN-1:0]    opa;
	logic [XLEN-1:0]    opb;
	res_t               res;

	// The input stage moves on whenever the result register is free or is
	// being emptied in this cycle.
	assign adv      = vld_s1 && (!out_vld_q || m_tready);
	assign s_tready = !vld_s1 || adv;
	assign acc      = s_tvalid && s_tready;
	assign wr_en    = adv && res.reg_written;
	assign rs_in    = s_tdata[25:21];
	assign rt_in    = s_tdata[20:16];

	mse_ram #(
		.WIDTH(XLEN),
		.DEPTH(RegCount)
	) u_rf (
		.clk     (clk),
		.we      (wr_en),
		.waddr   (res.dest_index),
		.wdata   (res.dest_value),
		.re      (acc),
		.raddr_a (rs_in),
		.raddr_b (rt_in),
		.rdata_a (ram_a),
		.rdata_b (ram_b)
	);

	assign opa = fwd_a_s1 ? fwd_val_s1 : (rdv_a_s1 ? ram_a : '0);
	assign opb = fwd_b_s1 ? fwd_val_s1 : (rdv_b_s1 ? ram_b : '0);

	mse_exec u_exec (
		.instr    (instr_s1),
		.opa      (opa),
		.opb      (opb),
		.pc       (pc_q),
		.prog_len (len_q),
		.res      (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			out_vld_q <= 1'b0;
			pc_q      <= '0;
			len_q     <= '0;
			rf_vld_q  <= '0;
		end else begin
			if (acc) begin
				vld_s1 <= 1'b1;
			end else if (adv) begin
				vld_s1 <= 1'b0;
			end
			if (adv) begin
				out_vld_q <= 1'b1;
				pc_q      <= res.next_pc;
			end else if (m_tready) begin
				out_vld_q <= 1'b0;
			end
			if (wr_en) begin
				rf_vld_q[res.dest_index] <= 1'b1;
			end
			if (cfg_wen) begin
				len_q <= cfg_wdata;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			instr_s1   <= s_tdata;
			rdv_a_s1   <= rf_vld_q[rs_in];
			rdv_b_s1   <= rf_vld_q[rt_in];
			fwd_a_s1   <= wr_en && (res.dest_index == rs_in);
			fwd_b_s1   <= wr_en && (res.dest_index == rt_in);
			fwd_val_s1 <= res.dest_value;
		end
		if (adv) begin
			out_q <= res;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = out_q;

`ifndef SYNTH
	// Register zero is never written.
	a_no_r0_write: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (res.dest_index != '0))
		else $error("write to register zero");

	// A finished program reports no register write and no unknown opcode.
	a_done_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld_q && out_q.done_res) |-> (!out_q.reg_written && !out_q.unknown_op))
		else $error("done result carries other flags");

	// The program counter only moves when an item executes.
	a_pc_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(pc_q))
		else $error("program counter moved without an executed item");

	// The register file is written only by an executing item.
	a_wr_adv: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (vld_s1 && !res.done_res))
		else $error("register write without an executing item");
`endif

endmodule

// ===== verif/tb.sv =====
// Self-checking testbench for the MIPS subset execute unit.
`timescale 1ns / 1ps

module tb;
	import mse_pkg::*;

	// A length row value that leaves the program length as it is.
	localparam int KEEP_LENGTH = -1;
	// A function code outside the supported set under the special opcode.
	localparam logic [5:0] FN_UNUSED = 6'h3F;
	// Length of the one long receiver hold-off, in cycles.
	localparam int HOLD_OFF_CYCLES = 80;

	// One row of the directed script: an optional length write, then one instruction word.
	typedef struct {
		int          length;
		logic [31:0] word;
		bit          typed;
		res_t        want;
	} script_row_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [31:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [71:0] m_tdata;
	logic        cfg_wen;
	logic [LenW-1:0] cfg_wdata;

	// Shadow architectural state, advanced once per accepted instruction.
	logic [31:0] gpr [RegCount];
	logic [31:0] cur_pc;
	int unsigned prog_len;

	res_t        pending_results [$];
	script_row_t script [$];
	int          mismatch_count;
	bit          quiet;
	int          hold_asked;

	mips_subset_execute_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_wen   (cfg_wen),
		.cfg_wdata (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("Verification failed");
		$finish;
	end

	function automatic logic [31:0] rtype(input logic [5:0] fn, input logic [4:0] rd,
			input logic [4:0] rs, input logic [4:0] rt, input logic [4:0] sa);
		return {OP_SPECIAL, rs, rt, rd, sa, fn};
	endfunction

	function automatic logic [31:0] itype(input logic [5:0] op, input logic [4:0] rs,
			input logic [4:0] rt, input logic [15:0] imm);
		return {op, rs, rt, imm};
	endfunction

	function automatic res_t want(input logic done, input logic unk, input logic [31:0] pc,
			input logic wr, input logic [4:0] idx, input logic [31:0] val);
		res_t r;
		r = '0;
		r.done_res = done;
		r.unknown_op = unk;
		r.next_pc = pc;
		r.reg_written = wr;
		r.dest_index = idx;
		r.dest_value = val;
		return r;
	endfunction

	function automatic int unsigned effective_length();
		return (prog_len > PROG_DEPTH) ? PROG_DEPTH : prog_len;
	endfunction

	function automatic bit program_finished();
		return (cur_pc >> 2) >= effective_length();
	endfunction

	// Executes one instruction word on the shadow state and returns the result item.
	function automatic res_t execute_word(input logic [31:0] w);
		res_t        r;
		logic [5:0]  op;
		logic [5:0]  fn;
		logic [4:0]  rs;
		logic [4:0]  rt;
		logic [4:0]  rd;
		logic [4:0]  sa;
		logic [4:0]  dst;
		logic [31:0] a;
		logic [31:0] b;
		logic [31:0] imm;
		logic [31:0] val;
		logic [31:0] nxt;
		logic        wr;
		logic        unk;
		r = '0;
		if (program_finished()) begin
			r.done_res = 1'b1;
			r.next_pc = cur_pc;
			return r;
		end
		op = w[31:26];
		rs = w[25:21];
		rt = w[20:16];
		rd = w[15:11];
		sa = w[10:6];
		fn = w[5:0];
		imm = {{16{w[15]}}, w[15:0]};
		a = gpr[rs];
		b = gpr[rt];
		nxt = cur_pc + 32'd4;
		val = '0;
		dst = '0;
		wr = 1'b0;
		unk = 1'b0;
		case (op)
			OP_SPECIAL: begin
				wr = 1'b1;
				dst = rd;
				case (fn)
					FN_ADD: val = a + b;
					FN_AND: val = a & b;
					FN_OR:  val = a | b;
					FN_SLL: val = b << sa;
					FN_SLT: val = {31'b0, $signed(a) < $signed(b)};
					FN_SRA: val = $unsigned($signed(b) >>> sa);
					FN_SRL: val = b >> sa;
					default: begin
						wr = 1'b0;
						unk = 1'b1;
					end
				endcase
			end
			OP_ADDI: begin
				wr = 1'b1;
				dst = rt;
				val = a + imm;
			end
			OP_BEQ: if (a == b) nxt = nxt + (imm << 2);
			OP_BNE: if (a != b) nxt = nxt + (imm << 2);
			default: unk = 1'b1;
		endcase
		// Writes to register zero are dropped and reported as no write.
		if (wr && dst == '0) wr = 1'b0;
		if (wr) begin
			gpr[dst] = val;
		end else begin
			dst = '0;
			val = '0;
		end
		cur_pc = nxt;
		r.unknown_op = unk;
		r.next_pc = nxt;
		r.reg_written = wr;
		r.dest_index = dst;
		r.dest_value = val;
		return r;
	endfunction

	// Idle length: mostly a few cycles, now and then a long stretch.
	function automatic int idle_len();
		int k;
		k = $urandom_range(0, 99);
		if (k < 75) return $urandom_range(1, 3);
		if (k < 93) return $urandom_range(4, 8);
		return $urandom_range(15, 40);
	endfunction

	// Random instruction whose branch target stays inside the current program.
	function automatic logic [31:0] random_instr();
		logic [31:0] w;
		int          k;
		int unsigned tgt;
		w = $urandom();
		k = $urandom_range(0, 99);
		if (k < 45) begin
			w[31:26] = OP_SPECIAL;
			case ($urandom_range(0, 6))
				0: w[5:0] = FN_ADD;
				1: w[5:0] = FN_AND;
				2: w[5:0] = FN_OR;
				3: w[5:0] = FN_SLL;
				4: w[5:0] = FN_SLT;
				5: w[5:0] = FN_SRA;
				default: w[5:0] = FN_SRL;
			endcase
		end else if (k < 70) begin
			w[31:26] = OP_ADDI;
		end else if (k < 85) begin
			w[31:26] = $urandom_range(0, 1) ? OP_BEQ : OP_BNE;
			// Equal source registers make the branch outcome certain.
			if ($urandom_range(0, 2) == 0) w[20:16] = w[25:21];
		end else if (k < 93) begin
			if ($urandom_range(0, 1)) begin
				while (w[31:26] == OP_SPECIAL || w[31:26] == OP_ADDI ||
						w[31:26] == OP_BEQ || w[31:26] == OP_BNE)
					w[31:26] = 6'($urandom());
			end else begin
				w[31:26] = OP_SPECIAL;
				while (w[5:0] == FN_ADD || w[5:0] == FN_AND || w[5:0] == FN_OR ||
						w[5:0] == FN_SLL || w[5:0] == FN_SLT || w[5:0] == FN_SRA ||
						w[5:0] == FN_SRL)
					w[5:0] = 6'($urandom());
			end
		end
		// A branch must never leave the program, or the counter could run off for good.
		if (w[31:26] == OP_BEQ || w[31:26] == OP_BNE) begin
			tgt = $urandom_range(0, effective_length() - 1);
			w[15:0] = 16'(tgt - (cur_pc >> 2) - 1);
		end
		return w;
	endfunction

	// Branch that always goes to the given word address.
	function automatic logic [31:0] jump_to(input int unsigned word_addr);
		return itype(OP_BEQ, 5'd0, 5'd0, 16'(word_addr - (cur_pc >> 2) - 1));
	endfunction

	task automatic compare_field(input string name, input logic [31:0] e, input logic [31:0] a);
		if (e !== a) begin
			$display("%0t: %s mismatch, expected %h, got %h", $time, name, e, a);
			mismatch_count++;
		end
	endtask

	task automatic check_result(input res_t got);
		res_t exp;
		if (pending_results.size() == 0) begin
			$display("%0t: result %h arrived with no instruction outstanding", $time, got);
			mismatch_count++;
			return;
		end
		exp = pending_results.pop_front();
		compare_field("done_res", exp.done_res, got.done_res);
		compare_field("unknown_op", exp.unknown_op, got.unknown_op);
		compare_field("next_pc", exp.next_pc, got.next_pc);
		compare_field("reg_written", exp.reg_written, got.reg_written);
		compare_field("dest_index", exp.dest_index, got.dest_index);
		compare_field("dest_value", exp.dest_value, got.dest_value);
	endtask

	// Flops and continuous logic read here still hold the values seen at this edge.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) check_result(m_tdata);
	end

	// Result side: random stalls, a long hold-off on request, none in quiet phases.
	initial begin
		int stall_left;
		int hold_left;
		int hold_served;
		stall_left = 0;
		hold_left = 0;
		hold_served = 0;
		m_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_served != hold_asked) begin
				hold_served++;
				hold_left = HOLD_OFF_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (quiet) begin
				m_tready <= 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else if ($urandom_range(0, 99) < 70) begin
				m_tready <= 1'b1;
			end else begin
				stall_left = idle_len() - 1;
				m_tready <= 1'b0;
			end
		end
	end

	// Offers one instruction item and books its result once the block takes it.
	task automatic push_instr(input logic [31:0] w, input bit typed = 1'b0,
			input res_t typed_want = '0);
		int   gap;
		res_t r;
		gap = (quiet || $urandom_range(0, 99) < 65) ? 0 : idle_len();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= w;
		do @(posedge clk); while (!s_tready);
		r = execute_word(w);
		pending_results.push_back(typed ? typed_want : r);
	endtask

	// Stops offering and waits until the block has delivered everything.
	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_length(input int unsigned len);
		drain_results();
		cfg_wen <= 1'b1;
		cfg_wdata <= LenW'(len);
		@(posedge clk);
		cfg_wen <= 1'b0;
		prog_len = len;
	endtask

	initial begin
		int unsigned lens [8];
		int          counts [8];
		int          done_sent;
		lens = '{1024, 7, 600, 1, 2047, 300, 1023, 2};
		counts = '{200, 60, 150, 20, 150, 100, 100, 20};
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		cfg_wen = 1'b0;
		cfg_wdata = '0;
		quiet = 1'b0;
		hold_asked = 0;
		mismatch_count = 0;
		foreach (gpr[i]) gpr[i] = '0;
		cur_pc = '0;
		prog_len = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed script. The first rows are simple enough to spell out the result.
		// Right after reset the length is zero, so the first item only reports done.
		script.push_back('{KEEP_LENGTH, itype(OP_ADDI, 5'd0, 5'd1, 16'd5), 1'b1,
			want(1'b1, 1'b0, 32'd0, 1'b0, 5'd0, 32'd0)});
		// Largest length; the depth clamp applies.
		script.push_back('{2047, itype(OP_ADDI, 5'd0, 5'd1, 16'h7FFF), 1'b1,
			want(1'b0, 1'b0, 32'd4, 1'b1, 5'd1, 32'h0000_7FFF)});
		script.push_back('{KEEP_LENGTH, itype(OP_ADDI, 5'd0, 5'd2, 16'h8000), 1'b1,
			want(1'b0, 1'b0, 32'd8, 1'b1, 5'd2, 32'hFFFF_8000)});
		// Destination register zero executes but writes nothing.
		script.push_back('{KEEP_LENGTH, itype(OP_ADDI, 5'd1, 5'd0, 16'd1), 1'b1,
			want(1'b0, 1'b0, 32'd12, 1'b0, 5'd0, 32'd0)});
		// Unknown opcode, then unknown function code.
		script.push_back('{KEEP_LENGTH, 32'hFFFF_FFFF, 1'b1,
			want(1'b0, 1'b1, 32'd16, 1'b0, 5'd0, 32'd0)});
		script.push_back('{KEEP_LENGTH, rtype(FN_UNUSED, 5'd3, 5'd1, 5'd2, 5'd0), 1'b1,
			want(1'b0, 1'b1, 32'd20, 1'b0, 5'd0, 32'd0)});
		script.push_back('{KEEP_LENGTH, rtype(FN_ADD, 5'd3, 5'd1, 5'd2, 5'd0), 1'b0, '0});
		script.push_back('{KEEP_LENGTH, rtype(FN_AND, 5'd4, 5'd1, 5'd2, 5'd0), 1'b0, '0});
		script.push_back('{KEEP_LENGTH, rtype(FN_OR, 5'd5, 5'd1, 5'd2, 5'd0), 1'b0, '0});
		script.push_back('{KEEP_LENGTH, rtype(FN_SLL, 5'd6, 5'd0, 5'd2, 5'd31), 1'b0, '0});
		script.push_back('{KEEP_LENGTH, rtype(FN_SRL, 5'd7, 5'd0, 5'd2, 5'd31), 1'b0, '0});
		script.push_back('{KEEP_LENGTH, rtype(FN_SRA, 5'd8, 5'd0, 5'd2, 5'd31), 1'b0, '0});
		script.push_back('{KEEP_LENGTH, rtype(FN_SRA, 5'd9, 5'd0, 5'd2, 5'd0), 1'b0, '0});
		// Signed compare: a negative source is less than a positive one.
		script.push_back('{KEEP_LENGTH, rtype(FN_SLT, 5'd10, 5'd2, 5'd1, 5'd0), 1'b0, '0});
		script.push_back('{KEEP_LENGTH, rtype(FN_SLT, 5'd11, 5'd1, 5'd2, 5'd0), 1'b0, '0});
		// Build a large positive value, then overflow it with addi and add.
		script.push_back('{KEEP_LENGTH, rtype(FN_SRL, 5'd13, 5'd0, 5'd2, 5'd1), 1'b0, '0});
		script.push_back('{KEEP_LENGTH, itype(OP_ADDI, 5'd13, 5'd14, 16'h7FFF), 1'b0, '0});
		script.push_back('{KEEP_LENGTH, rtype(FN_ADD, 5'd15, 5'd14, 5'd14, 5'd0), 1'b0, '0});
		// Branches: taken forward, not taken, taken backward, not taken far, self loop.
		script.push_back('{KEEP_LENGTH, itype(OP_BEQ, 5'd1, 5'd1, 16'd2), 1'b0, '0});
		script.push_back('{KEEP_LENGTH, itype(OP_BNE, 5'd1, 5'd1, 16'd5), 1'b0, '0});
		script.push_back('{KEEP_LENGTH, itype(OP_BNE, 5'd1, 5'd2, 16'hFFFD), 1'b0, '0});
		script.push_back('{KEEP_LENGTH, itype(OP_BEQ, 5'd1, 5'd2, 16'h7FFF), 1'b0, '0});
		script.push_back('{KEEP_LENGTH, itype(OP_BEQ, 5'd0, 5'd0, 16'hFFFF), 1'b0, '0});
		// Zero length stops the program, a longer one lets it go on.
		script.push_back('{0, itype(OP_ADDI, 5'd0, 5'd1, 16'd1), 1'b0, '0});
		script.push_back('{1023, itype(OP_ADDI, 5'd1, 5'd16, 16'h8001), 1'b0, '0});

		foreach (script[i]) begin
			if (script[i].length != KEEP_LENGTH) write_length(script[i].length);
			push_instr(script[i].word, script[i].typed, script[i].want);
		end

		// Random programs under a range of lengths. A phase ends after a couple of
		// done items, or else with a branch home so the next length starts at zero.
		foreach (lens[p]) begin
			write_length(lens[p]);
			quiet = (p == 5);
			if (p == 2) hold_asked <= hold_asked + 1;
			done_sent = 0;
			for (int i = 0; i < counts[p]; i++) begin
				if (program_finished()) begin
					if (done_sent == 2) break;
					done_sent++;
					push_instr($urandom());
				end else begin
					push_instr(random_instr());
					if ($urandom_range(0, 99) == 0) drain_results();
				end
			end
			if (!program_finished()) push_instr(jump_to(0));
		end
		quiet = 1'b0;

		// Run off the end of a full-depth program with the length above the depth.
		write_length(2047);
		push_instr(jump_to(PROG_DEPTH - 2));
		while (!program_finished())
			push_instr(itype(OP_ADDI, 5'($urandom()), 5'($urandom()), 16'($urandom())));
		repeat (2) push_instr($urandom());

		drain_results();
		repeat (10) @(posedge clk);
		if (mismatch_count == 0 && pending_results.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
